### hdl/heatmap_color_lookup_defines.svh
// Assertion macros used by the checker of the heatmap color lookup.
`ifndef HEATMAP_COLOR_LOOKUP_DEFINES_SVH
`define HEATMAP_COLOR_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while the reset is high.
`define HCL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcl: same-cycle property failed");

// Next-cycle implication, disabled while the reset is high.
`define HCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcl: next-cycle property failed");

// Next-cycle implication that is checked during reset as well.
`define HCL_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hcl: reset property failed");

`endif

### hdl/hcl_pkg.sv
// Shared constants of the heatmap color lookup.
`timescale 1ns / 1ps

package hcl_pkg;

   // Field widths.
   localparam int SAMPLE_W    = 32;
   localparam int INDEX_W     = 10;
   localparam int COLOR_W     = 16;
   localparam int NORM_W      = 17;
   localparam int ENTRIES_W   = 11;
   localparam int PRODUCT_W   = 64;
   localparam int POSITION_W  = 28;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Default table size.
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALUE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_RANGE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE = 2'd2;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0]  MIN_VALUE_RESET      = 32'd0;
   localparam logic [SAMPLE_W-1:0]  INVERSE_RANGE_RESET  = 32'd65536;
   localparam logic [ENTRIES_W-1:0] ENTRIES_IN_USE_RESET = 11'd1024;

   // Transaction kinds.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_MAP   = 1'b1;

   // One in Q1.16 and the rounding half of the blend.
   localparam logic [NORM_W-1:0] NORM_ONE = 17'd65536;
   localparam int BLEND_ROUND = 32768;

endpackage

### hdl/hcl_ifs.sv
// Request and response channel interfaces of the heatmap color lookup.
`timescale 1ns / 1ps

interface hcl_req_if;
   import hcl_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       action;
   logic signed [SAMPLE_W-1:0] sample;
   logic [INDEX_W-1:0]         entry_index;
   logic [COLOR_W-1:0]         entry_red;
   logic [COLOR_W-1:0]         entry_green;
   logic [COLOR_W-1:0]         entry_blue;

   modport source (
      output valid, action, sample, entry_index, entry_red, entry_green, entry_blue,
      input  ready
   );

   modport sink (
      input  valid, action, sample, entry_index, entry_red, entry_green, entry_blue,
      output ready
   );
endinterface

interface hcl_rsp_if;
   import hcl_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic [NORM_W-1:0]  normalized;

   modport source (
      output valid, red, green, blue, normalized,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue, normalized,
      output ready
   );
endinterface

### hdl/heatmap_color_lookup.sv
// Heatmap color lookup: a nine-stage pipeline that maps samples to interpolated RGB colors.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle on req_chan while rsp_chan does not stall.
// A map transaction (action 1) normalizes the sample as (sample - min_value) * inverse_range,
// clamps it to [0,1], scales it by the clamped entries_in_use - 1 and blends the two
// neighboring color table entries; its result leaves rsp_chan from the output stage. A write
// transaction (action 0) loads one table entry as it enters the table stage and gives no
// result; a map accepted after a write always sees it. The rate of one transaction per cycle,
// while rsp_chan does not stall, is set by the nine register stages and the table memory with
// one write port and two read ports, one for each neighbor. A stalled response holds the
// output stage while earlier stages keep filling their bubbles. Table entries are undefined
// after reset and have no clearing pass; software must load them before it maps.
// Configuration must be written only while the block is idle. The block enforces neither.
module heatmap_color_lookup #(
   parameter int TABLE_DEPTH = hcl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   hcl_req_if.sink                          req_chan,
   hcl_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [hcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hcl_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import hcl_pkg::*;

   localparam int ADDR_W     = $clog2(TABLE_DEPTH);
   localparam int NUM_STAGES = 9;
   localparam int RGB_W      = 3 * COLOR_W;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int BLEND_W    = 35;

   // Configuration registers.
   logic [SAMPLE_W-1:0]  min_value_ff;
   logic [SAMPLE_W-1:0]  inverse_range_ff;
   logic [ENTRIES_W-1:0] entries_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff      <= MIN_VALUE_RESET;
         inverse_range_ff  <= INVERSE_RANGE_RESET;
         entries_in_use_ff <= ENTRIES_IN_USE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_VALUE:      min_value_ff      <= csr_write_data;
            CSR_INVERSE_RANGE:  inverse_range_ff  <= csr_write_data;
            CSR_ENTRIES_IN_USE: entries_in_use_ff <= csr_write_data[ENTRIES_W-1:0];
            default: ;
         endcase
      end
   end

   // Entry count limited to the range two to table depth.
   logic [ENTRIES_W-1:0] entries_clamped;
   logic [ENTRIES_W-1:0] entries_less_one;
   logic [ENTRIES_W-1:0] entries_less_two;

   always_comb begin
      if (entries_in_use_ff < ENTRIES_W'(2)) begin
         entries_clamped = ENTRIES_W'(2);
      end else if (32'(entries_in_use_ff) > 32'(TABLE_DEPTH)) begin
         entries_clamped = ENTRIES_W'(TABLE_DEPTH);
      end else begin
         entries_clamped = entries_in_use_ff;
      end
      entries_less_one = entries_clamped - ENTRIES_W'(1);
      entries_less_two = entries_clamped - ENTRIES_W'(2);
   end

   // Stage valid bits and the advance chain: a stage loads when it is empty or its
   // successor loads.
   logic [NUM_STAGES:1] stage_valid_ff;
   logic [NUM_STAGES:1] stage_valid_in;
   logic [NUM_STAGES:1] stage_go;

   // Per-stage payload registers.
   logic                     s1_map_ff, s2_map_ff, s3_map_ff, s4_map_ff, s5_map_ff, s6_map_ff;
   logic [INDEX_W-1:0]       s1_index_ff, s2_index_ff, s3_index_ff;
   logic [INDEX_W-1:0]       s4_index_ff, s5_index_ff, s6_index_ff;
   logic [RGB_W-1:0]         s1_rgb_ff, s2_rgb_ff, s3_rgb_ff, s4_rgb_ff, s5_rgb_ff, s6_rgb_ff;
   logic [DIFF_W-1:0]        s1_diff_ff;
   logic [DIFF_W-1:0]        s1_diff_in;
   logic [SAMPLE_W-1:0]      s2_mag_diff_ff, s2_mag_inv_ff;
   logic [SAMPLE_W-1:0]      s2_mag_diff_in, s2_mag_inv_in;
   logic                     s2_positive_ff, s3_positive_ff;
   logic                     s2_positive_in;
   logic [PRODUCT_W-1:0]     s3_product_ff;
   logic [NORM_W-1:0]        s4_norm_ff, s5_norm_ff, s6_norm_ff, s7_norm_ff, s8_norm_ff;
   logic [NORM_W-1:0]        s4_norm_in;
   logic [POSITION_W-1:0]    s5_position_ff;
   logic [ENTRIES_W-1:0]     s6_entry_in;
   logic [POSITION_W-1:0]    s6_frac_wide;
   logic [ADDR_W-1:0]        s6_addr_lo_ff, s6_addr_hi_ff;
   logic [NORM_W-1:0]        s6_frac_ff, s7_frac_ff;
   logic [RGB_W-1:0]         s7_lo_ff, s7_hi_ff, s8_lo_ff;
   logic signed [BLEND_W-1:0] s8_step_ff [3];
   logic signed [BLEND_W-1:0] s8_step_in [3];
   logic [COLOR_W-1:0]       s9_color_ff [3];
   logic [COLOR_W-1:0]       s9_color_in [3];
   logic [NORM_W-1:0]        s9_norm_ff;

   // Advance chain from the output back to the input.
   always_comb begin
      stage_go[NUM_STAGES] = !stage_valid_ff[NUM_STAGES] || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_go[k] = !stage_valid_ff[k] || stage_go[k + 1];
      end
   end

   // Valid bits follow their transactions; write transactions retire at the table stage.
   always_comb begin
      stage_valid_in[1] = req_chan.valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         stage_valid_in[k] = stage_valid_ff[k - 1];
      end
      stage_valid_in[7] = stage_valid_ff[6] && s6_map_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_go[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   end

   assign req_chan.ready = stage_go[1];

   // Stage 1: distance from the configured minimum.
   assign s1_diff_in = {req_chan.sample[SAMPLE_W-1], req_chan.sample}
                     - {min_value_ff[SAMPLE_W-1], min_value_ff};

   always_ff @(posedge clock) begin
      if (stage_go[1]) begin
         s1_map_ff   <= (req_chan.action == ACTION_MAP);
         s1_index_ff <= req_chan.entry_index;
         s1_rgb_ff   <= {req_chan.entry_blue, req_chan.entry_green, req_chan.entry_red};
         s1_diff_ff  <= s1_diff_in;
      end
   end

   // Stage 2: magnitudes and the sign of the product.
   always_comb begin
      logic [DIFF_W-1:0] neg_diff;
      neg_diff       = ~s1_diff_ff + DIFF_W'(1);
      s2_mag_diff_in = s1_diff_ff[DIFF_W-1] ? neg_diff[SAMPLE_W-1:0] : s1_diff_ff[SAMPLE_W-1:0];
      s2_mag_inv_in  = inverse_range_ff[SAMPLE_W-1] ? (~inverse_range_ff + SAMPLE_W'(1))
                                                    : inverse_range_ff;
      s2_positive_in = (s1_diff_ff[DIFF_W-1] == inverse_range_ff[SAMPLE_W-1]);
   end

   always_ff @(posedge clock) begin
      if (stage_go[2]) begin
         s2_map_ff      <= s1_map_ff;
         s2_index_ff    <= s1_index_ff;
         s2_rgb_ff      <= s1_rgb_ff;
         s2_mag_diff_ff <= s2_mag_diff_in;
         s2_mag_inv_ff  <= s2_mag_inv_in;
         s2_positive_ff <= s2_positive_in;
      end
   end

   // Stage 3: unsigned 32 by 32 product in Q16.48.
   always_ff @(posedge clock) begin
      if (stage_go[3]) begin
         s3_map_ff      <= s2_map_ff;
         s3_index_ff    <= s2_index_ff;
         s3_rgb_ff      <= s2_rgb_ff;
         s3_product_ff  <= PRODUCT_W'(s2_mag_diff_ff) * PRODUCT_W'(s2_mag_inv_ff);
         s3_positive_ff <= s2_positive_ff;
      end
   end

   // Stage 4: clamp to [0,1]; a negative product maps to zero.
   always_comb begin
      if (!s3_positive_ff) begin
         s4_norm_in = '0;
      end else if (s3_product_ff[PRODUCT_W-1:48] != '0) begin
         s4_norm_in = NORM_ONE;
      end else begin
         s4_norm_in = {1'b0, s3_product_ff[47:32]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go[4]) begin
         s4_map_ff   <= s3_map_ff;
         s4_index_ff <= s3_index_ff;
         s4_rgb_ff   <= s3_rgb_ff;
         s4_norm_ff  <= s4_norm_in;
      end
   end

   // Stage 5: position along the table in Q.16.
   always_ff @(posedge clock) begin
      if (stage_go[5]) begin
         s5_map_ff      <= s4_map_ff;
         s5_index_ff    <= s4_index_ff;
         s5_rgb_ff      <= s4_rgb_ff;
         s5_norm_ff     <= s4_norm_ff;
         s5_position_ff <= POSITION_W'(s4_norm_ff) * POSITION_W'(entries_less_one);
      end
   end

   // Stage 6: entry index limited to the last pair, and the blend fraction.
   always_comb begin
      if (s5_position_ff[POSITION_W-1:FRAC_W] > {1'b0, entries_less_two}) begin
         s6_entry_in = entries_less_two;
      end else begin
         s6_entry_in = s5_position_ff[FRAC_W+ENTRIES_W-1:FRAC_W];
      end
      s6_frac_wide = s5_position_ff - POSITION_W'({s6_entry_in, {FRAC_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (stage_go[6]) begin
         s6_map_ff     <= s5_map_ff;
         s6_index_ff   <= s5_index_ff;
         s6_rgb_ff     <= s5_rgb_ff;
         s6_norm_ff    <= s5_norm_ff;
         s6_addr_lo_ff <= ADDR_W'(s6_entry_in);
         s6_addr_hi_ff <= ADDR_W'(s6_entry_in + ENTRIES_W'(1));
         s6_frac_ff    <= s6_frac_wide[NORM_W-1:0];
      end
   end

   // Stage 7: color table with one write port and two registered read ports.
   logic [RGB_W-1:0] table_mem [TABLE_DEPTH];
   logic             table_write;

   assign table_write = stage_valid_ff[6] && stage_go[7] && !s6_map_ff
                     && (32'(s6_index_ff) < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (table_write) begin
         table_mem[ADDR_W'(s6_index_ff)] <= s6_rgb_ff;
      end
      if (stage_go[7]) begin
         s7_lo_ff <= table_mem[s6_addr_lo_ff];
         s7_hi_ff <= table_mem[s6_addr_hi_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go[7]) begin
         s7_norm_ff <= s6_norm_ff;
         s7_frac_ff <= s6_frac_ff;
      end
   end

   // Stage 8: per channel, the step between neighbors times the fraction.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [COLOR_W:0] step;
         step = $signed({1'b0, s7_hi_ff[c*COLOR_W +: COLOR_W]})
              - $signed({1'b0, s7_lo_ff[c*COLOR_W +: COLOR_W]});
         s8_step_in[c] = BLEND_W'(step * $signed({1'b0, s7_frac_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go[8]) begin
         s8_lo_ff   <= s7_lo_ff;
         s8_norm_ff <= s7_norm_ff;
         for (int c = 0; c < 3; c++) begin
            s8_step_ff[c] <= s8_step_in[c];
         end
      end
   end

   // Stage 9: rounded blend, lo + (step * f + half) >> 16, into the output register.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [BLEND_W-1:0] rounded;
         logic signed [BLEND_W-1:0] total;
         rounded = (s8_step_ff[c] + BLEND_W'(BLEND_ROUND)) >>> FRAC_W;
         total   = $signed({{(BLEND_W-COLOR_W){1'b0}}, s8_lo_ff[c*COLOR_W +: COLOR_W]}) + rounded;
         s9_color_in[c] = total[COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go[9]) begin
         s9_norm_ff <= s8_norm_ff;
         for (int c = 0; c < 3; c++) begin
            s9_color_ff[c] <= s9_color_in[c];
         end
      end
   end

   // Response channel.
   assign rsp_chan.valid      = stage_valid_ff[NUM_STAGES];
   assign rsp_chan.red        = s9_color_ff[0];
   assign rsp_chan.green      = s9_color_ff[1];
   assign rsp_chan.blue       = s9_color_ff[2];
   assign rsp_chan.normalized = s9_norm_ff;

endmodule

### hdl/hcl_checker.sv
// Port-level checker of the heatmap color lookup and its bind statement.
`timescale 1ns / 1ps
`include "heatmap_color_lookup_defines.svh"

module hcl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hcl_pkg::COLOR_W-1:0]   rsp_red,
   input logic [hcl_pkg::COLOR_W-1:0]   rsp_green,
   input logic [hcl_pkg::COLOR_W-1:0]   rsp_blue,
   input logic [hcl_pkg::NORM_W-1:0]    rsp_normalized
);
   import hcl_pkg::*;

   // Whole response payload, watched as one vector.
   logic [3*COLOR_W+NORM_W-1:0] rsp_payload;
   assign rsp_payload = {rsp_red, rsp_green, rsp_blue, rsp_normalized};

   // A ready response side means every stage advances, so the request side is ready.
   `HCL_ASSERT_IMPLY(a_ready_follows, clock, 1'b0, rsp_ready, req_ready)

   // Nothing is presented in the cycle after a reset.
   `HCL_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // An empty pipeline after a reset takes a request at once.
   `HCL_ASSERT_ALWAYS_NEXT(a_reset_ready, clock, reset, req_ready)

   // A clamped normalized value never exceeds one, and one selects the top entry fully.
   `HCL_ASSERT_IMPLY(a_norm_range, clock, reset, rsp_valid, rsp_normalized <= NORM_ONE)

   // A stalled response transaction holds its payload.
   `HCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind heatmap_color_lookup hcl_checker u_hcl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_red        (rsp_chan.red),
   .rsp_green      (rsp_chan.green),
   .rsp_blue       (rsp_chan.blue),
   .rsp_normalized (rsp_chan.normalized)
);
